// ----- hdl/qrs_pkg.sv -----
package qrs_pkg;

  // Coefficient format
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_W      = 16;

  // Derived datapath widths
  localparam int DEN_W   = DATA_WIDTH + 1;              // divisor: 2*|a|, |a| or |b|
  localparam int QA_W    = DATA_WIDTH + 2 * FRAC_BITS;  // |c| << 2F quotient
  localparam int DM_W    = 2 * DATA_WIDTH + 1;          // |b*b - 4ac|
  localparam int SQ_MAX  = (QA_W > DM_W) ? QA_W : DM_W;
  localparam int SQ_R_W  = (SQ_MAX + 1) / 2;            // root bits
  localparam int SQ_IN_W = 2 * SQ_R_W;                  // radicand bits
  localparam int N_W     = SQ_R_W + 1;                  // |-b +/- s|
  localparam int QB_W    = N_W + FRAC_BITS;
  localparam int QD_W    = (QA_W > QB_W) ? QA_W : QB_W; // divider width

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [DATA_WIDTH-1:0]        mag_t;
  typedef logic [2*DATA_WIDTH-1:0]      prod_t;
  typedef logic [DM_W-1:0]              dm_t;
  typedef logic [DEN_W-1:0]             den_t;
  typedef logic [QD_W-1:0]              qd_t;
  typedef logic [SQ_IN_W-1:0]           sqi_t;
  typedef logic [SQ_R_W-1:0]            sqr_t;
  typedef logic [SQ_R_W+1:0]            sqrem_t;
  typedef logic signed [N_W:0]          ns_t;
  typedef logic [TOL_W-1:0]             tol_t;
  typedef logic [1:0]                   cnt_t;

  // Root count codes
  localparam cnt_t CNT_NONE = 2'b00;
  localparam cnt_t CNT_ONE  = 2'b01;
  localparam cnt_t CNT_TWO  = 2'b10;
  localparam cnt_t CNT_INF  = 2'b11;

  localparam mag_t  MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // How the roots of an item are formed at the end of the pipe
  typedef enum logic [2:0] {
    K_NONE,   // no computed root, roots read zero
    K_SQRT,   // roots -s and s
    K_ZC,     // roots 0 and one quotient
    K_ONE,    // single quotient root
    K_TWO     // two quotient roots from the discriminant
  } kind_t;

  // Per-item sideband that travels with the datapath
  typedef struct packed {
    kind_t kind;
    cnt_t  cnt;
    logic  neg;
    logic  neg1;
    logic  a_neg;
    data_t b;
    den_t  den;
    qd_t   nb;
    sqi_t  sq;
  } side_t;

  // Signed saturation of a magnitude to the output range
  function automatic data_t sat(input logic neg, input qd_t m);
    qd_t lim;
    qd_t nm;
    lim = qd_t'(MAX_POS);
    nm  = -m;
    if (neg) begin
      if (m > lim + qd_t'(1)) sat = MIN_NEG;
      else sat = data_t'(nm[DATA_WIDTH-1:0]);
    end else begin
      if (m > lim) sat = data_t'(lim[DATA_WIDTH-1:0]);
      else sat = data_t'(m[DATA_WIDTH-1:0]);
    end
  endfunction

endpackage

// ----- hdl/qrs_if.sv -----
interface qrs_coef_if;
  logic               valid;
  logic               ready;
  qrs_pkg::data_t     coef_a;
  qrs_pkg::data_t     coef_b;
  qrs_pkg::data_t     coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_res_if;
  logic               valid;
  logic               ready;
  qrs_pkg::cnt_t      root_count;
  qrs_pkg::data_t     root_low;
  qrs_pkg::data_t     root_high;
  modport source (output valid, root_count, root_low, root_high, input ready);
  modport sink (input valid, root_count, root_low, root_high, output ready);
endinterface

interface qrs_cfg_if;
  logic               valid;
  logic               ready;
  qrs_pkg::tol_t      zero_tolerance;
  modport source (output valid, zero_tolerance, input ready);
  modport sink (input valid, zero_tolerance, output ready);
endinterface

// ----- hdl/qrs_front.sv -----
module qrs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  qrs_pkg::data_t      a,
  input  qrs_pkg::data_t      b,
  input  qrs_pkg::data_t      c,
  input  qrs_pkg::tol_t       tol,
  output logic                out_valid,
  output qrs_pkg::side_t      out_side,
  output qrs_pkg::qd_t        na,
  output qrs_pkg::den_t       da
);

  // Stage 1: magnitudes and zero flags
  logic           v1;
  qrs_pkg::mag_t  ma1, mb1, mc1;
  logic           an1, bn1, cn1, za1, zb1, zc1;
  qrs_pkg::data_t b1;

  qrs_pkg::mag_t  ma_c, mb_c, mc_c;

  assign ma_c = a[qrs_pkg::DATA_WIDTH-1] ? qrs_pkg::mag_t'(-a) : qrs_pkg::mag_t'(a);
  assign mb_c = b[qrs_pkg::DATA_WIDTH-1] ? qrs_pkg::mag_t'(-b) : qrs_pkg::mag_t'(b);
  assign mc_c = c[qrs_pkg::DATA_WIDTH-1] ? qrs_pkg::mag_t'(-c) : qrs_pkg::mag_t'(c);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma1 <= ma_c;
      mb1 <= mb_c;
      mc1 <= mc_c;
      an1 <= a[qrs_pkg::DATA_WIDTH-1];
      bn1 <= b[qrs_pkg::DATA_WIDTH-1];
      cn1 <= c[qrs_pkg::DATA_WIDTH-1];
      za1 <= ma_c <= qrs_pkg::mag_t'(tol);
      zb1 <= mb_c <= qrs_pkg::mag_t'(tol);
      zc1 <= mc_c <= qrs_pkg::mag_t'(tol);
      b1  <= b;
    end
  end

  // Stage 2: products b*b and a*c
  logic            v2;
  qrs_pkg::mag_t   ma2, mb2, mc2;
  logic            an2, bn2, cn2, za2, zb2, zc2;
  qrs_pkg::data_t  b2s;
  qrs_pkg::prod_t  bb, ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bb  <= qrs_pkg::prod_t'(mb1) * qrs_pkg::prod_t'(mb1);
      ac  <= qrs_pkg::prod_t'(ma1) * qrs_pkg::prod_t'(mc1);
      ma2 <= ma1;
      mb2 <= mb1;
      mc2 <= mc1;
      an2 <= an1;
      bn2 <= bn1;
      cn2 <= cn1;
      za2 <= za1;
      zb2 <= zb1;
      zc2 <= zc1;
      b2s <= b1;
    end
  end

  // Stage 3: discriminant magnitude and sign
  logic            v3;
  qrs_pkg::mag_t   ma3, mb3, mc3;
  logic            an3, bn3, cn3, za3, zb3, zc3;
  qrs_pkg::data_t  b3;
  qrs_pkg::dm_t    dm3;
  logic            dneg3;

  qrs_pkg::dm_t    bb_e, ac4, dm_c;
  logic            dneg_c;

  assign bb_e = qrs_pkg::dm_t'(bb);
  assign ac4  = qrs_pkg::dm_t'({ac, 2'b00});

  always_comb begin
    dneg_c = 1'b0;
    if (an2 != cn2) begin
      dm_c = bb_e + ac4;
    end else if (bb_e >= ac4) begin
      dm_c = bb_e - ac4;
    end else begin
      dm_c   = ac4 - bb_e;
      dneg_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm3   <= dm_c;
      dneg3 <= dneg_c;
      ma3   <= ma2;
      mb3   <= mb2;
      mc3   <= mc2;
      an3   <= an2;
      bn3   <= bn2;
      cn3   <= cn2;
      za3   <= za2;
      zb3   <= zb2;
      zc3   <= zc2;
      b3    <= b2s;
    end
  end

  // Stage 4: pick the case and set up the divide and root operands
  qrs_pkg::side_t  side_next;
  logic            dz;

  assign dz = qrs_pkg::dm_t'({tol, {qrs_pkg::FRAC_BITS{1'b0}}}) >= dm3;

  always_comb begin
    side_next       = '0;
    side_next.kind  = qrs_pkg::K_NONE;
    side_next.cnt   = qrs_pkg::CNT_NONE;
    side_next.a_neg = an3;
    side_next.b     = b3;
    side_next.den   = qrs_pkg::den_t'({ma3, 1'b0});
    side_next.nb    = qrs_pkg::qd_t'({mb3, {qrs_pkg::FRAC_BITS{1'b0}}});
    side_next.sq    = qrs_pkg::sqi_t'(dm3);
    if (!za3) begin
      if (zb3 && zc3) begin
        side_next.cnt = qrs_pkg::CNT_ONE;
      end else if (zb3) begin
        if (cn3 != an3) begin
          side_next.cnt  = qrs_pkg::CNT_TWO;
          side_next.kind = qrs_pkg::K_SQRT;
        end
      end else if (zc3) begin
        side_next.cnt  = qrs_pkg::CNT_TWO;
        side_next.kind = qrs_pkg::K_ZC;
        side_next.neg  = (bn3 == an3);
        side_next.den  = qrs_pkg::den_t'(ma3);
      end else if (dz) begin
        side_next.cnt  = qrs_pkg::CNT_ONE;
        side_next.kind = qrs_pkg::K_ONE;
        side_next.neg  = (!bn3) != an3;
      end else if (!dneg3) begin
        side_next.cnt  = qrs_pkg::CNT_TWO;
        side_next.kind = qrs_pkg::K_TWO;
      end
    end else if (!zb3) begin
      side_next.cnt  = qrs_pkg::CNT_ONE;
      side_next.kind = qrs_pkg::K_ONE;
      side_next.neg  = (cn3 == bn3);
      side_next.nb   = qrs_pkg::qd_t'({mc3, {qrs_pkg::FRAC_BITS{1'b0}}});
      side_next.den  = qrs_pkg::den_t'(mb3);
    end else begin
      side_next.cnt = zc3 ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_next;
      na       <= qrs_pkg::qd_t'({mc3, {(2*qrs_pkg::FRAC_BITS){1'b0}}});
      da       <= qrs_pkg::den_t'(ma3);
    end
  end

endmodule

// ----- hdl/qrs_div.sv -----
module qrs_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  qrs_pkg::side_t      in_side,
  input  qrs_pkg::qd_t        num0,
  input  qrs_pkg::qd_t        num1,
  input  qrs_pkg::den_t       den,
  output logic                out_valid,
  output qrs_pkg::side_t      out_side,
  output qrs_pkg::qd_t        q0,
  output qrs_pkg::qd_t        q1
);

  localparam int DEPTH = qrs_pkg::QD_W;
  localparam int DW    = qrs_pkg::DEN_W;

  // One quotient bit per stage, two lanes on a shared divisor
  logic            vld [DEPTH];
  qrs_pkg::side_t  sd  [DEPTH];
  qrs_pkg::den_t   dn  [DEPTH];
  qrs_pkg::den_t   ra  [DEPTH];
  qrs_pkg::den_t   rb  [DEPTH];
  qrs_pkg::qd_t    qa  [DEPTH];
  qrs_pkg::qd_t    qb  [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    logic            v_i;
    qrs_pkg::side_t  s_i;
    qrs_pkg::den_t   d_i, ra_i, rb_i;
    qrs_pkg::qd_t    qa_i, qb_i;
    logic [DW:0]     ta, tb, sa, sb;
    logic            ga, gb;

    if (k == 0) begin : g_head
      assign v_i  = in_valid;
      assign s_i  = in_side;
      assign d_i  = den;
      assign ra_i = '0;
      assign rb_i = '0;
      assign qa_i = num0;
      assign qb_i = num1;
    end else begin : g_body
      assign v_i  = vld[k-1];
      assign s_i  = sd[k-1];
      assign d_i  = dn[k-1];
      assign ra_i = ra[k-1];
      assign rb_i = rb[k-1];
      assign qa_i = qa[k-1];
      assign qb_i = qb[k-1];
    end

    // Shift in the next dividend bit and trial-subtract
    assign ta = {ra_i, qa_i[DEPTH-1]};
    assign tb = {rb_i, qb_i[DEPTH-1]};
    assign sa = ta - {1'b0, d_i};
    assign sb = tb - {1'b0, d_i};
    assign ga = ta >= {1'b0, d_i};
    assign gb = tb >= {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k] <= s_i;
        dn[k] <= d_i;
        ra[k] <= ga ? sa[DW-1:0] : ta[DW-1:0];
        rb[k] <= gb ? sb[DW-1:0] : tb[DW-1:0];
        qa[k] <= {qa_i[DEPTH-2:0], ga};
        qb[k] <= {qb_i[DEPTH-2:0], gb};
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_side  = sd[DEPTH-1];
  assign q0        = qa[DEPTH-1];
  assign q1        = qb[DEPTH-1];

endmodule

// ----- hdl/qrs_sqrt.sv -----
module qrs_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  qrs_pkg::side_t      in_side,
  input  qrs_pkg::sqi_t       op,
  output logic                out_valid,
  output qrs_pkg::side_t      out_side,
  output qrs_pkg::sqr_t       root
);

  localparam int DEPTH = qrs_pkg::SQ_R_W;
  localparam int IW    = qrs_pkg::SQ_IN_W;

  // One root bit per stage
  logic            vld [DEPTH];
  qrs_pkg::side_t  sd  [DEPTH];
  qrs_pkg::sqrem_t rm  [DEPTH];
  qrs_pkg::sqr_t   rt  [DEPTH];
  qrs_pkg::sqi_t   xs  [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    logic              v_i;
    qrs_pkg::side_t    s_i;
    qrs_pkg::sqrem_t   r_i;
    qrs_pkg::sqr_t     q_i;
    qrs_pkg::sqi_t     x_i;
    logic [DEPTH+3:0]  t, test, diff;
    logic              ge;

    if (k == 0) begin : g_head
      assign v_i = in_valid;
      assign s_i = in_side;
      assign r_i = '0;
      assign q_i = '0;
      assign x_i = op;
    end else begin : g_body
      assign v_i = vld[k-1];
      assign s_i = sd[k-1];
      assign r_i = rm[k-1];
      assign q_i = rt[k-1];
      assign x_i = xs[k-1];
    end

    // Bring down two radicand bits and test 4*root + 1
    assign t    = {r_i, x_i[IW-1 -: 2]};
    assign test = (DEPTH+4)'({q_i, 2'b01});
    assign diff = t - test;
    assign ge   = t >= test;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k] <= s_i;
        rm[k] <= ge ? diff[DEPTH+1:0] : t[DEPTH+1:0];
        rt[k] <= {q_i[DEPTH-2:0], ge};
        xs[k] <= {x_i[IW-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_side  = sd[DEPTH-1];
  assign root      = rt[DEPTH-1];

endmodule

// ----- hdl/qrs_mid.sv -----
module qrs_mid (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  qrs_pkg::side_t      in_side,
  input  qrs_pkg::sqr_t       root,
  output logic                out_valid,
  output qrs_pkg::side_t      out_side,
  output qrs_pkg::qd_t        num0,
  output qrs_pkg::qd_t        num1
);

  localparam int NW = qrs_pkg::N_W;

  qrs_pkg::ns_t    negb, s_e, n1, n2;
  logic [NW-1:0]   m1, m2;
  qrs_pkg::side_t  side_next;
  logic            two;

  // Form -b - s and -b + s with their magnitudes
  assign negb = -qrs_pkg::ns_t'(in_side.b);
  assign s_e  = qrs_pkg::ns_t'(root);
  assign n1   = negb - s_e;
  assign n2   = negb + s_e;
  assign m1   = n1[NW] ? NW'(-n1) : NW'(n1);
  assign m2   = n2[NW] ? NW'(-n2) : NW'(n2);
  assign two  = in_side.kind == qrs_pkg::K_TWO;

  always_comb begin
    side_next = in_side;
    if (two) begin
      side_next.neg  = n1[NW] != in_side.a_neg;
      side_next.neg1 = n2[NW] != in_side.a_neg;
    end
    if (in_side.kind == qrs_pkg::K_SQRT) begin
      side_next.sq = qrs_pkg::sqi_t'(root);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_next;
      num0     <= two ? qrs_pkg::qd_t'({m1, {qrs_pkg::FRAC_BITS{1'b0}}}) : in_side.nb;
      num1     <= qrs_pkg::qd_t'({m2, {qrs_pkg::FRAC_BITS{1'b0}}});
    end
  end

endmodule

// ----- hdl/quadratic_root_solver_core.sv -----
// Channel   Dir  Payload                               Handshake
// coef      in   coef_a, coef_b, coef_c (Q16.16)       valid/ready
// result    out  root_count, root_low, root_high       valid/ready
// cfg       in   zero_tolerance (16 bits)              valid/ready, ready always high
//
// One coefficient triple per clock while the skid register is empty. The Q16.16
// datapath runs through the front, the first bit-per-stage divider, the
// bit-per-stage square root, the numerator stage and the second divider.
// Synchronous active-high reset clears all valid bits and the tolerance.
// A stalled result sits in the output register; one more result lands in
// the skid register, which then freezes the whole pipe until it drains.
module quadratic_root_solver_core (
  input  logic      clk,
  input  logic      rst,
  qrs_coef_if.sink  coef,
  qrs_res_if.source result,
  qrs_cfg_if.sink   cfg
);

  // Tolerance register
  qrs_pkg::tol_t tol;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg.valid) begin
      tol <= cfg.zero_tolerance;
    end
  end

  // Pipe advances whenever the skid register is empty
  logic en;
  logic skid_vld;

  assign en         = !skid_vld;
  assign coef.ready = en;

  // Front: magnitudes, products, discriminant, case select
  logic            fv;
  qrs_pkg::side_t  fs;
  qrs_pkg::qd_t    fna;
  qrs_pkg::den_t   fda;

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (coef.valid),
    .a         (coef.coef_a),
    .b         (coef.coef_b),
    .c         (coef.coef_c),
    .tol       (tol),
    .out_valid (fv),
    .out_side  (fs),
    .na        (fna),
    .da        (fda)
  );

  // First divider: (|c| << 2F) / |a| for the b-zero case
  logic            av;
  qrs_pkg::side_t  as_;
  qrs_pkg::qd_t    aq;

  qrs_div u_div_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv),
    .in_side   (fs),
    .num0      (fna),
    .num1      ('0),
    .den       (fda),
    .out_valid (av),
    .out_side  (as_),
    .q0        (aq),
    .q1        ()
  );

  // Square root of either that quotient or the discriminant
  qrs_pkg::sqi_t   sq_op;
  logic            sv;
  qrs_pkg::side_t  ss;
  qrs_pkg::sqr_t   sroot;

  assign sq_op = (as_.kind == qrs_pkg::K_SQRT) ?
                 qrs_pkg::sqi_t'(aq[qrs_pkg::QA_W-1:0]) : as_.sq;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (av),
    .in_side   (as_),
    .op        (sq_op),
    .out_valid (sv),
    .out_side  (ss),
    .root      (sroot)
  );

  // Numerators for the final divides
  logic            mv;
  qrs_pkg::side_t  ms;
  qrs_pkg::qd_t    mn0, mn1;

  qrs_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sv),
    .in_side   (ss),
    .root      (sroot),
    .out_valid (mv),
    .out_side  (ms),
    .num0      (mn0),
    .num1      (mn1)
  );

  // Second divider: both roots share the divisor
  logic            bv;
  qrs_pkg::side_t  bs;
  qrs_pkg::qd_t    bq0, bq1;

  qrs_div u_div_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mv),
    .in_side   (ms),
    .num0      (mn0),
    .num1      (mn1),
    .den       (ms.den),
    .out_valid (bv),
    .out_side  (bs),
    .q0        (bq0),
    .q1        (bq1)
  );

  // Saturate and order the roots
  qrs_pkg::data_t  fin_lo, fin_hi, x0, x1, sp, sn;

  assign x0 = qrs_pkg::sat(bs.neg, bq0);
  assign x1 = qrs_pkg::sat(bs.neg1, bq1);
  assign sn = qrs_pkg::sat(1'b1, qrs_pkg::qd_t'(bs.sq[qrs_pkg::SQ_R_W-1:0]));
  assign sp = qrs_pkg::sat(1'b0, qrs_pkg::qd_t'(bs.sq[qrs_pkg::SQ_R_W-1:0]));

  always_comb begin
    fin_lo = '0;
    fin_hi = '0;
    case (bs.kind)
      qrs_pkg::K_SQRT: begin
        fin_lo = sn;
        fin_hi = sp;
      end
      qrs_pkg::K_ZC: begin
        if (bs.neg) fin_lo = x0;
        else fin_hi = x0;
      end
      qrs_pkg::K_ONE: begin
        fin_lo = x0;
      end
      qrs_pkg::K_TWO: begin
        fin_lo = bs.a_neg ? x1 : x0;
        fin_hi = bs.a_neg ? x0 : x1;
      end
      default: begin
        fin_lo = '0;
        fin_hi = '0;
      end
    endcase
  end

  // Output register with one skid entry behind it
  logic            res_vld;
  qrs_pkg::cnt_t   res_cnt, skid_cnt;
  qrs_pkg::data_t  res_lo, res_hi, skid_lo, skid_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!res_vld || result.ready) begin
      if (skid_vld) begin
        res_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        res_vld <= bv;
      end
    end else if (bv && en) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_vld || result.ready) begin
      if (skid_vld) begin
        res_cnt <= skid_cnt;
        res_lo  <= skid_lo;
        res_hi  <= skid_hi;
      end else begin
        res_cnt <= bs.cnt;
        res_lo  <= fin_lo;
        res_hi  <= fin_hi;
      end
    end else if (bv && en) begin
      skid_cnt <= bs.cnt;
      skid_lo  <= fin_lo;
      skid_hi  <= fin_hi;
    end
  end

  assign result.valid      = res_vld;
  assign result.root_count = res_cnt;
  assign result.root_low   = res_lo;
  assign result.root_high  = res_hi;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> res_vld)
    else $error("skid holds a beat while the output register is empty");

  a_skid_stalls_in: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> !coef.ready)
    else $error("input taken while the skid register is full");

  a_no_root_values: assert property (@(posedge clk) disable iff (rst)
    res_vld && (res_cnt == qrs_pkg::CNT_NONE || res_cnt == qrs_pkg::CNT_INF)
      |-> res_lo == '0 && res_hi == '0)
    else $error("root values present without finite roots");

  a_roots_ordered: assert property (@(posedge clk) disable iff (rst)
    res_vld && res_cnt == qrs_pkg::CNT_TWO |-> res_lo <= res_hi)
    else $error("two roots out of order");
`endif

endmodule

// ----- verif/quadratic_root_solver_core_test.sv -----
module quadratic_root_solver_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [127:0] u128_t;

  typedef struct {
    qrs_pkg::cnt_t  count;
    qrs_pkg::data_t low;
    qrs_pkg::data_t high;
  } roots_t;

  typedef struct {
    qrs_pkg::data_t a;
    qrs_pkg::data_t b;
    qrs_pkg::data_t c;
    bit             typed;
    roots_t         want;
  } coef_row_t;

  localparam qrs_pkg::data_t ONE_Q = 32'sh0001_0000;
  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD = 400;

  logic clk;
  logic rst;

  qrs_coef_if coef ();
  qrs_res_if  result ();
  qrs_cfg_if  cfg ();

  quadratic_root_solver_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .coef   (coef),
    .result (result),
    .cfg    (cfg)
  );

  roots_t        pending_roots[$];
  qrs_pkg::tol_t tol_now;
  int            mismatches;
  int            coef_beats;
  int            idle_cycles;
  int            burst_left;

  // Floor of the square root, one bit per pass
  function automatic logic [63:0] floor_sqrt(u128_t x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (u128_t'(t) * u128_t'(t) <= x) r = t;
    end
    return r;
  endfunction

  // Saturate a signed magnitude to the output range
  function automatic qrs_pkg::data_t clamp_root(bit neg, u128_t m);
    u128_t lim;
    lim = u128_t'(qrs_pkg::MAX_POS);
    if (neg) begin
      if (m > lim + 1) return qrs_pkg::MIN_NEG;
      return qrs_pkg::data_t'(-m[qrs_pkg::DATA_WIDTH-1:0]);
    end
    if (m > lim) return qrs_pkg::data_t'(qrs_pkg::MAX_POS);
    return qrs_pkg::data_t'(m[qrs_pkg::DATA_WIDTH-1:0]);
  endfunction

  function automatic qrs_pkg::data_t quot_root(bit neg, u128_t num, u128_t den);
    if (den == 0) return '0;
    return clamp_root(neg, num / den);
  endfunction

  function automatic u128_t mag_of(longint v);
    return v < 0 ? u128_t'(-v) : u128_t'(v);
  endfunction

  // Expected roots of one coefficient triple at the given tolerance
  function automatic roots_t solve_roots(qrs_pkg::data_t a, qrs_pkg::data_t b,
                                         qrs_pkg::data_t c, qrs_pkg::tol_t tol);
    roots_t r;
    u128_t ma, mb, mc, b2, ac, dm;
    bit za, zb, zc, dneg, same;
    longint s, n1, n2;
    qrs_pkg::data_t q, t;
    ma = mag_of(longint'(a));
    mb = mag_of(longint'(b));
    mc = mag_of(longint'(c));
    za = ma <= tol;
    zb = mb <= tol;
    zc = mc <= tol;
    r.count = qrs_pkg::CNT_NONE;
    r.low = '0;
    r.high = '0;
    if (!za) begin
      if (zb && zc) begin
        r.count = qrs_pkg::CNT_ONE;
      end else if (zb) begin
        if ((c < 0) != (a < 0)) begin
          s = longint'(floor_sqrt((mc << (2 * qrs_pkg::FRAC_BITS)) / ma));
          r.count = qrs_pkg::CNT_TWO;
          r.low = clamp_root(1'b1, u128_t'(s));
          r.high = clamp_root(1'b0, u128_t'(s));
        end
      end else if (zc) begin
        same = (b < 0) == (a < 0);
        q = quot_root(same, mb << qrs_pkg::FRAC_BITS, ma);
        r.count = qrs_pkg::CNT_TWO;
        if (same) r.low = q;
        else r.high = q;
      end else begin
        b2 = mb * mb;
        ac = (ma * mc) << 2;
        dneg = 1'b0;
        if ((a < 0) != (c < 0)) dm = b2 + ac;
        else if (b2 >= ac) dm = b2 - ac;
        else begin
          dm = ac - b2;
          dneg = 1'b1;
        end
        if ((u128_t'(tol) << qrs_pkg::FRAC_BITS) >= dm) begin
          r.count = qrs_pkg::CNT_ONE;
          r.low = quot_root((b >= 0) != (a < 0), mb << qrs_pkg::FRAC_BITS, ma << 1);
        end else if (!dneg) begin
          s = longint'(floor_sqrt(dm));
          n1 = -longint'(b) - s;
          n2 = -longint'(b) + s;
          r.count = qrs_pkg::CNT_TWO;
          r.low = quot_root((n1 < 0) != (a < 0), mag_of(n1) << qrs_pkg::FRAC_BITS, ma << 1);
          r.high = quot_root((n2 < 0) != (a < 0), mag_of(n2) << qrs_pkg::FRAC_BITS, ma << 1);
          if (a < 0) begin
            t = r.low;
            r.low = r.high;
            r.high = t;
          end
        end
      end
    end else if (!zb) begin
      r.count = qrs_pkg::CNT_ONE;
      r.low = quot_root((c < 0) == (b < 0), mc << qrs_pkg::FRAC_BITS, mb);
    end else begin
      r.count = zc ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
    end
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive one coefficient beat, with bursts and random gaps on the sender side
  task automatic send_coefs(qrs_pkg::data_t a, qrs_pkg::data_t b, qrs_pkg::data_t c,
                            bit typed, roots_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
      if (gap > 0) begin
        coef.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    coef.valid  <= 1'b1;
    coef.coef_a <= a;
    coef.coef_b <= b;
    coef.coef_c <= c;
    @(posedge clk);
    while (!coef.ready) @(posedge clk);
    burst_left--;
    pending_roots.push_back(typed ? want : solve_roots(a, b, c, tol_now));
  endtask

  // Hold the sender until every result is back
  task automatic drain_results();
    coef.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  // Write the tolerance register while the pipe is empty
  task automatic write_tolerance(qrs_pkg::tol_t v);
    drain_results();
    cfg.valid <= 1'b1;
    cfg.zero_tolerance <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    tol_now = v;
    cfg.valid <= 1'b0;
  endtask

  // Random coefficient, biased toward the tolerance edge and the extremes
  function automatic qrs_pkg::data_t pick_coef(qrs_pkg::tol_t tol);
    qrs_pkg::data_t v;
    case ($urandom_range(0, 5))
      0: v = qrs_pkg::data_t'($urandom);
      1: v = qrs_pkg::data_t'($urandom_range(0, 32'(tol) + 2));
      2: v = qrs_pkg::data_t'($urandom_range(0, 32'h10_0000));
      3: v = qrs_pkg::data_t'($urandom_range(0, 32'h0400_0000));
      4: begin
        case ($urandom_range(0, 3))
          0: v = qrs_pkg::MIN_NEG;
          1: v = qrs_pkg::data_t'(qrs_pkg::MAX_POS);
          2: v = '0;
          default: v = 32'sd1;
        endcase
      end
      default: v = qrs_pkg::data_t'($urandom_range(0, 16) * ONE_Q);
    endcase
    if ($urandom_range(0, 1) && v != qrs_pkg::MIN_NEG) v = -v;
    return v;
  endfunction

  // Random triple: one in three built from chosen integer roots, the rest free
  task automatic send_random(qrs_pkg::tol_t tol);
    qrs_pkg::data_t a, b, c;
    int r1, r2, k;
    roots_t none;
    none = '{qrs_pkg::CNT_NONE, '0, '0};
    if ($urandom_range(0, 2) == 0) begin
      k = $urandom_range(1, 8) * ($urandom_range(0, 1) ? 1 : -1);
      r1 = $signed($urandom_range(0, 20)) - 10;
      r2 = ($urandom_range(0, 3) == 0) ? r1 : $signed($urandom_range(0, 20)) - 10;
      a = qrs_pkg::data_t'(k * ONE_Q);
      b = qrs_pkg::data_t'(-k * (r1 + r2) * ONE_Q);
      c = qrs_pkg::data_t'(k * r1 * r2 * ONE_Q);
    end else begin
      a = pick_coef(tol);
      b = pick_coef(tol);
      c = pick_coef(tol);
    end
    send_coefs(a, b, c, 1'b0, none);
  endtask

  // Receiver stall pattern, with one long hold-off early in the first long phase
  initial begin
    int mode;
    int hold_left;
    int span;
    bit hold_done;
    mode = 0;
    hold_left = 0;
    span = 0;
    hold_done = 1'b0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && coef_beats >= 60) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (span == 0) begin
        span = $urandom_range(16, 96);
        mode = $urandom_range(0, 3);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        case (mode)
          0: result.ready <= 1'b1;
          1: result.ready <= $urandom_range(0, 1);
          2: result.ready <= ($urandom_range(0, 4) == 0);
          default: result.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    roots_t exp_r;
    if (!rst && coef.valid && coef.ready) coef_beats <= coef_beats + 1;
    if (!rst && result.valid && result.ready) begin
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: count=%0d low=%h high=%h",
                   result.root_count, result.root_low, result.root_high);
      end else begin
        exp_r = pending_roots.pop_front();
        if (result.root_count !== exp_r.count || result.root_low !== exp_r.low ||
            result.root_high !== exp_r.high) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected count=%0d low=%h high=%h, got count=%0d low=%h high=%h",
                     exp_r.count, exp_r.low, exp_r.high,
                     result.root_count, result.root_low, result.root_high);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((coef.valid && coef.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    coef_row_t rows[$];
    qrs_pkg::tol_t tol_steps[$];
    roots_t none;
    none = '{qrs_pkg::CNT_NONE, '0, '0};
    mismatches = 0;
    coef_beats = 0;
    idle_cycles = 0;
    burst_left = 0;
    tol_now = '0;
    rst <= 1'b1;
    coef.valid <= 1'b0;
    coef.coef_a <= '0;
    coef.coef_b <= '0;
    coef.coef_c <= '0;
    cfg.valid <= 1'b0;
    cfg.zero_tolerance <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases at reset tolerance
    rows = '{
      '{32'sd0, 32'sd0, 32'sd0, 1'b1, '{qrs_pkg::CNT_INF, 32'sd0, 32'sd0}},
      '{32'sd0, 32'sd0, ONE_Q, 1'b1, '{qrs_pkg::CNT_NONE, 32'sd0, 32'sd0}},
      '{ONE_Q, 32'sd0, 32'sd0, 1'b1, '{qrs_pkg::CNT_ONE, 32'sd0, 32'sd0}},
      '{ONE_Q, 32'sd0, ONE_Q, 1'b1, '{qrs_pkg::CNT_NONE, 32'sd0, 32'sd0}},
      '{ONE_Q, 32'sd0, -4 * ONE_Q, 1'b1, '{qrs_pkg::CNT_TWO, -2 * ONE_Q, 2 * ONE_Q}},
      '{ONE_Q, -2 * ONE_Q, 32'sd0, 1'b1, '{qrs_pkg::CNT_TWO, 32'sd0, 2 * ONE_Q}},
      '{32'sd0, ONE_Q, -3 * ONE_Q, 1'b1, '{qrs_pkg::CNT_ONE, 3 * ONE_Q, 32'sd0}},
      '{ONE_Q, -2 * ONE_Q, ONE_Q, 1'b1, '{qrs_pkg::CNT_ONE, ONE_Q, 32'sd0}},
      '{ONE_Q, ONE_Q, ONE_Q, 1'b1, '{qrs_pkg::CNT_NONE, 32'sd0, 32'sd0}},
      '{ONE_Q, -3 * ONE_Q, 2 * ONE_Q, 1'b0, none},
      '{-ONE_Q, 3 * ONE_Q, -2 * ONE_Q, 1'b0, none},
      '{-ONE_Q, 32'sd0, 9 * ONE_Q, 1'b0, none},
      '{-ONE_Q, ONE_Q, 32'sd0, 1'b0, none},
      '{qrs_pkg::MIN_NEG, qrs_pkg::data_t'(qrs_pkg::MAX_POS), qrs_pkg::MIN_NEG, 1'b0, none},
      '{qrs_pkg::MIN_NEG, qrs_pkg::MIN_NEG, qrs_pkg::MIN_NEG, 1'b0, none},
      '{qrs_pkg::data_t'(qrs_pkg::MAX_POS), qrs_pkg::data_t'(qrs_pkg::MAX_POS),
        qrs_pkg::data_t'(qrs_pkg::MAX_POS), 1'b0, none},
      '{32'sd1, 32'sd0, qrs_pkg::MIN_NEG, 1'b0, none},
      '{32'sd1, qrs_pkg::data_t'(qrs_pkg::MAX_POS), 32'sd0, 1'b0, none},
      '{32'sd1, qrs_pkg::MIN_NEG, 32'sd0, 1'b0, none},
      '{32'sd0, 32'sd1, qrs_pkg::data_t'(qrs_pkg::MAX_POS), 1'b0, none},
      '{32'sd0, -32'sd1, qrs_pkg::MIN_NEG, 1'b0, none},
      '{-32'sd1, qrs_pkg::data_t'(qrs_pkg::MAX_POS), qrs_pkg::data_t'(qrs_pkg::MAX_POS),
        1'b0, none}
    };
    foreach (rows[i])
      send_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].typed, rows[i].want);

    // Random phases across tolerance settings; the first one is long enough
    // to fill the pipe while the receiver holds off
    tol_steps = '{16'd0, 16'hFFFF, 16'h0040, qrs_pkg::tol_t'($urandom), 16'd1};
    foreach (tol_steps[p]) begin
      write_tolerance(tol_steps[p]);
      repeat ((p == 0) ? 300 : 100) send_random(tol_now);
    end

    // Wait out the pipe, then settle
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/qrs_pkg.sv
hdl/qrs_if.sv
hdl/qrs_front.sv
hdl/qrs_div.sv
hdl/qrs_sqrt.sv
hdl/qrs_mid.sv
hdl/quadratic_root_solver_core.sv
verif/quadratic_root_solver_core_test.sv
